// ===== hw/rtl/hsi_pkg.sv =====
`default_nettype none

package hsi_pkg;

   localparam int HSI_HEIGHT_BITS = 16;
   localparam int HSI_FIELD_BITS  = 16;
   localparam int HSI_GAIN_BITS   = 15;
   localparam int HSI_LEVEL_BITS  = 8;
   localparam int HSI_OPND_BITS   = 24;   // multiplier operand width; also |gx|,|gy| width
   localparam int HSI_PROD_BITS   = 2 * HSI_OPND_BITS;
   localparam int HSI_SQ_BITS     = 49;   // gx^2 + gy^2
   localparam int HSI_TAB_BITS    = 48;   // tan^2 thresholds, unsigned Q32

   localparam logic [HSI_GAIN_BITS-1:0]  HSI_GAIN_RESET  = 15'd16384;
   localparam logic [HSI_LEVEL_BITS-1:0] HSI_SLOPE_STEPS = 8'd254;

   localparam logic [63:0] HSI_PI_Q30  = 64'd3373259426;
   localparam logic [63:0] HSI_ONE_Q30 = 64'd1 << 30;

   typedef logic [HSI_TAB_BITS-1:0] tan2_tab_type [256];

   typedef struct packed {
      logic start;
      logic ack;
   } hsi_ctl_type;

   typedef struct packed {
      logic                      done;
      logic [HSI_LEVEL_BITS-1:0] level;
   } hsi_stat_type;

   // restoring unsigned division, used only while the table is built
   function automatic logic [63:0] hsi_udiv64(input logic [63:0] n, input logic [63:0] d);
      logic [63:0] q;
      logic [64:0] r;
      q = '0;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[63:0], n[i]};
         if (r >= {1'b0, d}) begin
            r    = r - {1'b0, d};
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   // sin (odd) or cos (even) in Q30 by a 15-term series, evaluated at elaboration
   function automatic logic [63:0] hsi_trig_q30(input logic [63:0] x, input logic odd);
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] sum;
      logic [63:0] d;
      logic        sub;
      x2   = (x * x) >> 30;
      term = odd ? x : HSI_ONE_Q30;
      sum  = term;
      sub  = 1'b1;
      for (int n = 1; n <= 14; n++) begin
         d    = odd ? 64'((2 * n) * (2 * n + 1)) : 64'((2 * n - 1) * (2 * n));
         term = hsi_udiv64((term * x2) >> 30, d);
         sum  = sub ? sum - term : sum + term;
         sub  = !sub;
      end
      return sum;
   endfunction

   function automatic tan2_tab_type hsi_build_tan2();
      tan2_tab_type tab;
      logic [63:0]  x;
      logic [63:0]  s;
      logic [63:0]  c;
      logic [63:0]  t;
      logic [63:0]  th;
      logic [63:0]  tl;
      logic [63:0]  k64;
      tab[0]   = '0;
      tab[255] = '1;   // never selected by the search
      for (int k = 1; k <= 254; k++) begin
         k64 = 64'(k);
         x   = hsi_udiv64(k64 * HSI_PI_Q30 + 64'd255, 64'd510);
         s   = hsi_trig_q30(x, 1'b1);
         c   = hsi_trig_q30(x, 1'b0);
         if (s > HSI_ONE_Q30) s = HSI_ONE_Q30;
         if (c == 64'd0) c = 64'd1;
         t  = hsi_udiv64(s << 32, c);
         th = t >> 16;
         tl = t & 64'hFFFF;
         tab[k] = HSI_TAB_BITS'(th * th + ((64'd2 * th * tl + ((tl * tl) >> 16)) >> 16));
      end
      return tab;
   endfunction

   localparam tan2_tab_type HSI_TAN2_TAB = hsi_build_tan2();

endpackage

`default_nettype wire

// ===== hw/rtl/hsi_slope_unit.sv =====
`default_nettype none

module hsi_slope_unit #(
   parameter int HEIGHT_BITS = hsi_pkg::HSI_HEIGHT_BITS
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire hsi_pkg::hsi_ctl_type               ctl,
   input  wire logic [hsi_pkg::HSI_GAIN_BITS-1:0]  gain,
   input  wire logic [hsi_pkg::HSI_OPND_BITS-1:0]  ax,
   input  wire logic [hsi_pkg::HSI_OPND_BITS-1:0]  ay,
   output hsi_pkg::hsi_stat_type                   stat
);
   import hsi_pkg::*;

   localparam int SCALED_BITS = 40;   // (ax * gain) << 8
   localparam logic [SCALED_BITS-1:0] FS_W =
      SCALED_BITS'((64'd1 << HEIGHT_BITS) - 64'd1);

   typedef enum logic [3:0] {
      S_IDLE, S_MULX, S_FOLDX, S_MULY, S_FOLDY, S_SQX, S_SQY, S_SUM, S_SRCH, S_DONE
   } state_type;

   state_type                 state_ff, state_in;
   logic [SCALED_BITS-1:0]    rem_ff, rem_in;
   logic [HSI_OPND_BITS-1:0]  quo_ff, quo_in;
   logic [HSI_OPND_BITS-1:0]  gx_ff, gx_in;
   logic [HSI_OPND_BITS-1:0]  gy_ff, gy_in;
   logic [HSI_PROD_BITS-1:0]  sq_ff, sq_in;
   logic [HSI_SQ_BITS-1:0]    mag_ff, mag_in;
   logic [HSI_LEVEL_BITS-1:0] lvl_ff, lvl_in;
   logic [2:0]                bit_ff, bit_in;

   logic [HSI_OPND_BITS-1:0]  mul_a;
   logic [HSI_OPND_BITS-1:0]  mul_b;
   logic [HSI_PROD_BITS-1:0]  mul_p;
   logic [SCALED_BITS-1:0]    fold_hi;
   logic [SCALED_BITS-1:0]    fold_lo;
   logic [HSI_LEVEL_BITS-1:0] cand;
   logic                      take;

   // shared multiplier
   always_comb begin
      case (state_ff)
         S_MULX:  begin mul_a = ax;    mul_b = HSI_OPND_BITS'(gain); end
         S_MULY:  begin mul_a = ay;    mul_b = HSI_OPND_BITS'(gain); end
         S_SQX:   begin mul_a = gx_ff; mul_b = gx_ff; end
         S_SQY:   begin mul_a = gy_ff; mul_b = gy_ff; end
         default: begin mul_a = '0;    mul_b = '0; end
      endcase
   end
   assign mul_p = mul_a * mul_b;

   // one fold step of division by 2^H-1: r = hi*2^H + lo = hi*(2^H-1) + (hi+lo)
   assign fold_hi = rem_ff >> HEIGHT_BITS;
   assign fold_lo = rem_ff & FS_W;

   assign cand = lvl_ff | (HSI_LEVEL_BITS'(1) << bit_ff);
   assign take = (cand <= HSI_SLOPE_STEPS) &&
                 ({{(HSI_SQ_BITS-HSI_TAB_BITS){1'b0}}, HSI_TAN2_TAB[cand]} <= mag_ff);

   always_comb begin
      state_in = state_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      gx_in    = gx_ff;
      gy_in    = gy_ff;
      sq_in    = sq_ff;
      mag_in   = mag_ff;
      lvl_in   = lvl_ff;
      bit_in   = bit_ff;
      case (state_ff)
         S_IDLE: begin
            if (ctl.start) state_in = S_MULX;
         end
         S_MULX, S_MULY: begin
            rem_in   = {mul_p[SCALED_BITS-9:0], 8'd0};
            quo_in   = '0;
            state_in = (state_ff == S_MULX) ? S_FOLDX : S_FOLDY;
         end
         S_FOLDX, S_FOLDY: begin
            if (fold_hi != '0) begin
               quo_in = quo_ff + fold_hi[HSI_OPND_BITS-1:0];
               rem_in = fold_hi + fold_lo;
            end else if (state_ff == S_FOLDX) begin
               gx_in    = quo_ff + HSI_OPND_BITS'(fold_lo == FS_W);
               state_in = S_MULY;
            end else begin
               gy_in    = quo_ff + HSI_OPND_BITS'(fold_lo == FS_W);
               state_in = S_SQX;
            end
         end
         S_SQX: begin
            mag_in   = HSI_SQ_BITS'(mul_p);
            state_in = S_SQY;
         end
         S_SQY: begin
            sq_in    = mul_p;
            state_in = S_SUM;
         end
         S_SUM: begin
            mag_in   = mag_ff + HSI_SQ_BITS'(sq_ff);
            lvl_in   = '0;
            bit_in   = 3'd7;
            state_in = S_SRCH;
         end
         S_SRCH: begin
            // thresholds rise with k: build the count MSB first
            if (take) lvl_in = cand;
            if (bit_ff == 3'd0) state_in = S_DONE;
            else bit_in = bit_ff - 3'd1;
         end
         S_DONE: begin
            if (ctl.ack) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      gx_ff  <= gx_in;
      gy_ff  <= gy_in;
      sq_ff  <= sq_in;
      mag_ff <= mag_in;
      lvl_ff <= lvl_in;
      bit_ff <= bit_in;
   end

   assign stat.done  = (state_ff == S_DONE);
   assign stat.level = lvl_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/heightmap_slope_intensity_top.sv =====
// Slope intensity of a streamed heightmap, from 2x2 height gradients.
// req_* takes one column of the map per transfer, in raster order: the pixel
// height and the height one row below, with req_tlast on the last column of
// a row. rsp_* gives one 8-bit level per pixel, 0 flat up to 254 near
// vertical; rsp_tlast marks the last pixel of a row and rsp_tuser the last
// result caused by one input transfer. The first column of a row gives no
// result unless it ends the row; any other row-end column gives two (held
// pixel, then itself). csr_* writes the Q7.8 gradient gain; the user is to
// write it only while the block is idle, which the block itself does not enforce.
// Each result goes through one shared multiplier and compare unit: the
// start, the gain multiply and fold division by full scale of each
// gradient, the two squares, one add, 8 table-compare steps and a hand-off.
// req_tready is low while a result is in work.
// The result sits in an output register; the block takes the next column
// while it waits there, and a stalled receiver only holds back the next
// finished result. Reset clears the held column and the output valid, and
// sets the gain to 64.0.
`default_nettype none

module heightmap_slope_intensity_top #(
   parameter int HEIGHT_BITS = hsi_pkg::HSI_HEIGHT_BITS
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output      logic                                req_tready,
   input  wire logic [2*hsi_pkg::HSI_FIELD_BITS-1:0] req_tdata,  // height_top, height_bottom
   input  wire logic                                req_tlast,   // row_end
   output      logic                                rsp_tvalid,
   input  wire logic                                rsp_tready,
   output      logic [hsi_pkg::HSI_LEVEL_BITS-1:0]  rsp_tdata,   // slope_level
   output      logic                                rsp_tlast,   // row_last
   output      logic                                rsp_tuser,   // run_last
   input  wire logic                                csr_valid,
   output      logic                                csr_ready,
   input  wire logic [hsi_pkg::HSI_GAIN_BITS-1:0]   csr_data     // gradient_gain
);
   import hsi_pkg::*;

   localparam int IN_BITS = (HEIGHT_BITS < HSI_FIELD_BITS) ? HEIGHT_BITS : HSI_FIELD_BITS;
   localparam logic [HSI_FIELD_BITS-1:0] HMASK =
      HSI_FIELD_BITS'((64'd1 << IN_BITS) - 64'd1);
   localparam int SUM_BITS = HSI_FIELD_BITS + 1;

   function automatic logic [HSI_OPND_BITS-1:0] absdiff(input logic [SUM_BITS-1:0] p,
                                                          input logic [SUM_BITS-1:0] q);
      logic [SUM_BITS-1:0] d;
      d = (p >= q) ? p - q : q - p;
      return HSI_OPND_BITS'(d);
   endfunction

   logic                      busy_ff, busy_in;
   logic                      start_ff, start_in;
   logic                      pend_ff, pend_in;
   logic                      have_prior_ff, have_prior_in;
   logic [HSI_GAIN_BITS-1:0]  gain_ff, gain_in;
   logic                      rsp_tvalid_ff, rsp_tvalid_in;
   logic [HSI_FIELD_BITS-1:0] prior_top_ff, prior_top_in;
   logic [HSI_FIELD_BITS-1:0] prior_bot_ff, prior_bot_in;
   logic [HSI_OPND_BITS-1:0]  ax_ff, ax_in;
   logic [HSI_OPND_BITS-1:0]  ay_ff, ay_in;
   logic [HSI_OPND_BITS-1:0]  ayb_ff, ayb_in;
   logic                      row_last_ff, row_last_in;
   logic                      run_last_ff, run_last_in;
   logic [HSI_LEVEL_BITS-1:0] rsp_level_ff, rsp_level_in;
   logic                      rsp_last_ff, rsp_last_in;
   logic                      rsp_user_ff, rsp_user_in;

   logic                      accept;
   logic                      out_free;
   logic [HSI_FIELD_BITS-1:0] cur_top;
   logic [HSI_FIELD_BITS-1:0] cur_bot;
   logic [HSI_OPND_BITS-1:0]  ax_held;
   logic [HSI_OPND_BITS-1:0]  ay_held;
   logic [HSI_OPND_BITS-1:0]  ay_self;
   hsi_ctl_type               ctl;
   hsi_stat_type              stat;

   assign req_tready = !busy_ff;
   assign csr_ready  = 1'b1;
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   assign cur_top = req_tdata[HSI_FIELD_BITS-1:0] & HMASK;
   assign cur_bot = req_tdata[2*HSI_FIELD_BITS-1:HSI_FIELD_BITS] & HMASK;

   // held pixel uses the arriving column as right neighbor
   assign ax_held = absdiff(SUM_BITS'(cur_top) + SUM_BITS'(cur_bot),
                            SUM_BITS'(prior_top_ff) + SUM_BITS'(prior_bot_ff));
   assign ay_held = absdiff(SUM_BITS'(prior_bot_ff) + SUM_BITS'(cur_bot),
                            SUM_BITS'(prior_top_ff) + SUM_BITS'(cur_top));
   // row-end pixel is its own right neighbor: dx is zero
   assign ay_self = absdiff(SUM_BITS'(cur_bot) + SUM_BITS'(cur_bot),
                            SUM_BITS'(cur_top) + SUM_BITS'(cur_top));

   always_comb begin
      busy_in       = busy_ff;
      start_in      = 1'b0;
      pend_in       = pend_ff;
      have_prior_in = have_prior_ff;
      gain_in       = gain_ff;
      rsp_tvalid_in = rsp_tvalid_ff;
      prior_top_in  = prior_top_ff;
      prior_bot_in  = prior_bot_ff;
      ax_in         = ax_ff;
      ay_in         = ay_ff;
      ayb_in        = ayb_ff;
      row_last_in   = row_last_ff;
      run_last_in   = run_last_ff;
      rsp_level_in  = rsp_level_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_user_in   = rsp_user_ff;

      if (csr_valid) gain_in = csr_data;

      if (rsp_tvalid_ff && rsp_tready) rsp_tvalid_in = 1'b0;

      if (accept) begin
         ayb_in = ay_self;
         if (have_prior_ff) begin
            ax_in       = ax_held;
            ay_in       = ay_held;
            start_in    = 1'b1;
            busy_in     = 1'b1;
            row_last_in = 1'b0;
            run_last_in = !req_tlast;
            pend_in     = req_tlast;
         end else if (req_tlast) begin
            ax_in       = '0;
            ay_in       = ay_self;
            start_in    = 1'b1;
            busy_in     = 1'b1;
            row_last_in = 1'b1;
            run_last_in = 1'b1;
            pend_in     = 1'b0;
         end
         if (req_tlast) begin
            have_prior_in = 1'b0;
         end else begin
            prior_top_in  = cur_top;
            prior_bot_in  = cur_bot;
            have_prior_in = 1'b1;
         end
      end

      if (stat.done && out_free) begin
         rsp_tvalid_in = 1'b1;
         rsp_level_in  = stat.level;
         rsp_last_in   = row_last_ff;
         rsp_user_in   = run_last_ff;
         if (pend_ff) begin
            ax_in       = '0;
            ay_in       = ayb_ff;
            start_in    = 1'b1;
            row_last_in = 1'b1;
            run_last_in = 1'b1;
            pend_in     = 1'b0;
         end else begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         start_ff      <= 1'b0;
         pend_ff       <= 1'b0;
         have_prior_ff <= 1'b0;
         gain_ff       <= HSI_GAIN_RESET;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         start_ff      <= start_in;
         pend_ff       <= pend_in;
         have_prior_ff <= have_prior_in;
         gain_ff       <= gain_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      prior_top_ff <= prior_top_in;
      prior_bot_ff <= prior_bot_in;
      ax_ff        <= ax_in;
      ay_ff        <= ay_in;
      ayb_ff       <= ayb_in;
      row_last_ff  <= row_last_in;
      run_last_ff  <= run_last_in;
      rsp_level_ff <= rsp_level_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_user_ff  <= rsp_user_in;
   end

   assign ctl.start = start_ff;
   assign ctl.ack   = out_free;

   hsi_slope_unit #(
      .HEIGHT_BITS (HEIGHT_BITS)
   ) u_slope (
      .clock (clock),
      .reset (reset),
      .ctl   (ctl),
      .gain  (gain_ff),
      .ax    (ax_ff),
      .ay    (ay_ff),
      .stat  (stat)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_level_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/hsi_checker.sv =====
`default_nettype none

module hsi_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        req_tlast,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [7:0]  rsp_tdata,
   input wire logic        rsp_tlast,
   input wire logic        rsp_tuser
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
                                   $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // a row-end column always produces work, so the input side closes
   a_row_end_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("row end transfer did not start a result");

   // the last pixel of a row is always the last result of its transfer
   a_row_last_run_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser)
      else $error("row_last without run_last");

   // the level never reaches the vertical code
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata != 8'd255)
      else $error("slope level out of range");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind heightmap_slope_intensity_top hsi_checker u_hsi_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

// ===== dv/heightmap_slope_intensity_checker.sv =====
module heightmap_slope_intensity_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   input  logic                                 req_tready,
   input  logic [2*hsi_pkg::HSI_FIELD_BITS-1:0] req_tdata,   // height_top, height_bottom
   input  logic                                 req_tlast,   // row_end
   input  logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   input  logic [hsi_pkg::HSI_LEVEL_BITS-1:0]   rsp_tdata,   // slope_level
   input  logic                                 rsp_tlast,   // row_last
   input  logic                                 rsp_tuser,   // run_last
   input  logic                                 csr_valid,
   input  logic                                 csr_ready,
   input  logic [hsi_pkg::HSI_GAIN_BITS-1:0]    csr_data,    // gradient_gain
   output int                                   fail_count,
   output int                                   pending_count,
   output int                                   checked_count
);
   import hsi_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [63:0] FULL_SCALE  = (64'd1 << HSI_HEIGHT_BITS) - 64'd1;
   localparam logic [63:0] Q30_ONE     = 64'd1 << 30;
   localparam logic [63:0] PI_Q30      = 64'd3373259426;
   localparam int          LEVEL_STEPS = 254;

   typedef struct packed {
      logic [HSI_LEVEL_BITS-1:0] level;
      logic                      row_last;
      logic                      run_last;
   } slope_result_type;

   logic [63:0]      tan2_thresh [1:LEVEL_STEPS];
   logic [63:0]      gain_q88;
   logic [63:0]      held_top;
   logic [63:0]      held_bottom;
   logic             held_valid;
   slope_result_type expected_slopes [$];
   slope_result_type want;

   // Taylor series in Q30: sine when want_sin, else cosine
   function automatic logic [63:0] series_q30(input logic [63:0] x, input bit want_sin);
      logic [63:0] x2;
      logic [63:0] term;
      logic [63:0] acc;
      logic [63:0] div;
      bit          neg;
      x2   = (x * x) >> 30;
      term = want_sin ? x : Q30_ONE;
      acc  = term;
      neg  = 1'b1;
      for (int n = 1; n <= 14; n++) begin
         div  = want_sin ? 64'((2 * n) * (2 * n + 1)) : 64'((2 * n - 1) * (2 * n));
         term = ((term * x2) >> 30) / div;
         acc  = neg ? acc - term : acc + term;
         neg  = !neg;
      end
      return acc;
   endfunction

   initial begin
      logic [63:0] ang;
      logic [63:0] sn;
      logic [63:0] cs;
      logic [63:0] tq;
      logic [63:0] hi;
      logic [63:0] lo;
      for (int k = 1; k <= LEVEL_STEPS; k++) begin
         ang = (64'(k) * PI_Q30 + 64'd255) / 64'd510;
         sn  = series_q30(ang, 1'b1);
         cs  = series_q30(ang, 1'b0);
         if (sn > Q30_ONE) sn = Q30_ONE;
         if (cs == 64'd0) cs = 64'd1;
         tq = (sn << 32) / cs;
         hi = tq >> 16;
         lo = tq & 64'hFFFF;
         // square of a Q32 value, truncated back to Q32
         tan2_thresh[k] = hi * hi + ((64'd2 * hi * lo + ((lo * lo) >> 16)) >> 16);
      end
   end

   function automatic logic [HSI_LEVEL_BITS-1:0] slope_level_of(
      input logic [63:0] v00, input logic [63:0] v01,
      input logic [63:0] v10, input logic [63:0] v11);
      logic [63:0] ax;
      logic [63:0] ay;
      logic [63:0] gx;
      logic [63:0] gy;
      logic [63:0] mag2;
      int          lvl;
      ax   = (v10 + v11 >= v00 + v01) ? (v10 + v11) - (v00 + v01) : (v00 + v01) - (v10 + v11);
      ay   = (v01 + v11 >= v00 + v10) ? (v01 + v11) - (v00 + v10) : (v00 + v10) - (v01 + v11);
      gx   = (ax * gain_q88 * 64'd256) / FULL_SCALE;
      gy   = (ay * gain_q88 * 64'd256) / FULL_SCALE;
      mag2 = gx * gx + gy * gy;
      lvl  = 0;
      for (int k = 1; k <= LEVEL_STEPS; k++)
         if (mag2 >= tan2_thresh[k]) lvl++;
      return HSI_LEVEL_BITS'(lvl);
   endfunction

   task automatic predict_column(input logic [2*HSI_FIELD_BITS-1:0] data, input logic row_end);
      logic [63:0]      top;
      logic [63:0]      bot;
      slope_result_type r;
      top = 64'(data[HSI_FIELD_BITS-1:0]) & FULL_SCALE;
      bot = 64'(data[2*HSI_FIELD_BITS-1:HSI_FIELD_BITS]) & FULL_SCALE;
      if (held_valid) begin
         r.level    = slope_level_of(held_top, held_bottom, top, bot);
         r.row_last = 1'b0;
         r.run_last = !row_end;
         expected_slopes.push_back(r);
      end
      if (row_end) begin
         // last pixel of the row is its own right neighbor
         r.level    = slope_level_of(top, bot, top, bot);
         r.row_last = 1'b1;
         r.run_last = 1'b1;
         expected_slopes.push_back(r);
         held_valid = 1'b0;
      end else begin
         held_top    = top;
         held_bottom = bot;
         held_valid  = 1'b1;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         gain_q88    = 64'(HSI_GAIN_RESET);
         held_top    = '0;
         held_bottom = '0;
         held_valid  = 1'b0;
         expected_slopes.delete();
         fail_count    = 0;
         checked_count = 0;
      end else begin
         // compare before predicting so a same-edge request never feeds this result
         if (rsp_tvalid && rsp_tready) begin
            if (expected_slopes.size() == 0) begin
               $error("rsp transfer with no slope result pending: level %0d", rsp_tdata);
               fail_count++;
            end else begin
               want = expected_slopes.pop_front();
               checked_count++;
               if (rsp_tdata !== want.level) begin
                  $error("slope_level expected %0d got %0d", want.level, rsp_tdata);
                  fail_count++;
               end
               if (rsp_tlast !== want.row_last) begin
                  $error("row_last expected %0b got %0b", want.row_last, rsp_tlast);
                  fail_count++;
               end
               if (rsp_tuser !== want.run_last) begin
                  $error("run_last expected %0b got %0b", want.run_last, rsp_tuser);
                  fail_count++;
               end
            end
         end
         if (csr_valid && csr_ready)
            gain_q88 = 64'(csr_data);
         if (req_tvalid && req_tready)
            predict_column(req_tdata, req_tlast);
      end
      pending_count = expected_slopes.size();
   end

endmodule

// ===== dv/tb_heightmap_slope_intensity_top.sv =====
module tb_heightmap_slope_intensity_top;
   import hsi_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT    = 1_000_000;
   localparam int SETTLE_CYCLES  = 40;
   localparam int PHASE_COLUMNS  = 180;
   localparam int RANDOM_PHASES  = 8;

   logic                        clock;
   logic                        reset;
   logic                        req_tvalid;
   logic                        req_tready;
   logic [2*HSI_FIELD_BITS-1:0] req_tdata;   // height_top, height_bottom
   logic                        req_tlast;   // row_end
   logic                        rsp_tvalid;
   logic                        rsp_tready;
   logic [HSI_LEVEL_BITS-1:0]   rsp_tdata;   // slope_level
   logic                        rsp_tlast;   // row_last
   logic                        rsp_tuser;   // run_last
   logic                        csr_valid;
   logic                        csr_ready;
   logic [HSI_GAIN_BITS-1:0]    csr_data;    // gradient_gain

   int  fail_count;
   int  pending_count;
   int  checked_count;
   int  cycle_count;
   int  columns_sent;
   int  gain_writes;
   bit  req_burst;
   bit  rsp_burst;

   heightmap_slope_intensity_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   heightmap_slope_intensity_checker i_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tlast     (req_tlast),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .rsp_tuser     (rsp_tuser),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count),
      .checked_count (checked_count)
   );

   initial clock = 1'b0;
   always #10 clock = ~clock;

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("[heightmap_slope_intensity_top] ERROR");
      $finish;
   end

   // receiver: random stall before each result, with occasional no-stall stretches
   initial begin
      int hold;
      rsp_tready = 1'b0;
      rsp_burst  = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         if ($urandom_range(0, 39) == 0) rsp_burst = !rsp_burst;
         hold = rsp_burst ? 0 : $urandom_range(0, 19);
         if (hold > 0) begin
            rsp_tready = 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         @(negedge clock);
      end
   end

   function automatic logic [HSI_FIELD_BITS-1:0] clamp_height(input int v);
      if (v < 0) return '0;
      if (v > 65535) return '1;
      return HSI_FIELD_BITS'(v);
   endfunction

   // called and returns at a falling edge
   task automatic send_column(input logic [HSI_FIELD_BITS-1:0] top,
                              input logic [HSI_FIELD_BITS-1:0] bot,
                              input logic row_end);
      int gap;
      if ($urandom_range(0, 39) == 0) req_burst = !req_burst;
      gap = req_burst ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  = {bot, top};
      req_tlast  = row_end;
      req_tvalid = 1'b1;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      columns_sent++;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      if (req_tvalid) req_tvalid = 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_gain(input logic [HSI_GAIN_BITS-1:0] gain);
      csr_data  = gain;
      csr_valid = 1'b1;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      gain_writes++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // rows of a smooth random terrain; some rows are pure noise, some mimic the
   // final row (bottom repeats top), and some lose their row end
   task automatic send_terrain(input int count);
      int sent;
      int len;
      int kind;
      int scale;
      int h;
      int b;
      sent = 0;
      while (sent < count) begin
         len   = $urandom_range(1, 12);
         kind  = $urandom_range(0, 9);
         scale = 1 << $urandom_range(0, 16);
         h     = $urandom_range(0, 65535);
         for (int c = 0; c < len; c++) begin
            if (kind == 0) begin
               h = $urandom_range(0, 65535);
               b = $urandom_range(0, 65535);
            end else begin
               h = h + ($urandom_range(0, 1) ? 1 : -1) * $urandom_range(0, scale);
               h = clamp_height(h);
               if (kind == 1) b = h;
               else b = h + ($urandom_range(0, 1) ? 1 : -1) * $urandom_range(0, scale);
            end
            send_column(clamp_height(h), clamp_height(b),
                        (c == len - 1) && !(kind == 2 && sent + len < count));
         end
         sent += len;
      end
      // close the phase on a row boundary
      send_column(16'($urandom), 16'($urandom), 1'b1);
   endtask

   initial begin
      int gain;
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tlast    = 1'b0;
      csr_valid    = 1'b0;
      csr_data     = '0;
      req_burst    = 1'b0;
      columns_sent = 0;
      gain_writes  = 0;
      repeat (8) @(negedge clock);
      reset = 1'b0;
      @(negedge clock);

      // reset gain: lone row ends, full-scale steps, single-count differences
      send_column(16'd0, 16'd0, 1'b1);
      send_column(16'hFFFF, 16'd0, 1'b1);
      send_column(16'd0, 16'hFFFF, 1'b1);
      send_column(16'd0, 16'd0, 1'b0);
      send_column(16'hFFFF, 16'hFFFF, 1'b0);
      send_column(16'd0, 16'hFFFF, 1'b0);
      send_column(16'hFFFF, 16'd0, 1'b1);
      send_column(16'd12345, 16'd12345, 1'b0);
      send_column(16'd12346, 16'd12346, 1'b1);
      send_column(16'd32768, 16'd32767, 1'b0);
      send_column(16'd32767, 16'd32768, 1'b1);
      send_column(16'hFFFF, 16'hFFFF, 1'b1);
      wait_idle();

      // zero gain flattens everything
      write_gain('0);
      send_column(16'd0, 16'hFFFF, 1'b0);
      send_column(16'hFFFF, 16'd0, 1'b1);
      send_column(16'hFFFF, 16'd0, 1'b1);
      wait_idle();

      write_gain(15'd1);
      send_column(16'd0, 16'hFFFF, 1'b0);
      send_column(16'hFFFF, 16'd0, 1'b0);
      send_column(16'd0, 16'd0, 1'b1);
      wait_idle();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0, 6: gain = 16384;
            1: gain = 1;
            3: gain = 256;
            5: gain = $urandom_range(1, 1024);
            default: gain = $urandom_range(1, 16384);
         endcase
         write_gain(HSI_GAIN_BITS'(gain));
         send_terrain(PHASE_COLUMNS);
         wait_idle();
      end

      $display("sent %0d heightmap columns over %0d gain settings", columns_sent, gain_writes);
      $display("checked %0d slope results, %0d mismatches", checked_count, fail_count);
      if (fail_count == 0 && pending_count == 0)
         $display("[heightmap_slope_intensity_top] OK");
      else
         $display("[heightmap_slope_intensity_top] ERROR");
      $finish;
   end

endmodule
